/* rtl/core/interval_lagrange_weights_1d_assert.svh */
// Assertion macros for the interval Lagrange weights block.
`ifndef INTERVAL_LAGRANGE_WEIGHTS_1D_ASSERT_SVH
`define INTERVAL_LAGRANGE_WEIGHTS_1D_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define ILW_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define ILW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/ilw_pkg.sv */
// ---------------------------------------------------------------------------
// ilw_pkg
// Shared types and constants of the interval Lagrange weights block.
// ---------------------------------------------------------------------------
package ilw_pkg;

  localparam int unsigned MaxPointsDefault = 1024;
  localparam int unsigned CoordW = 32;
  localparam int unsigned IdxW = 10;
  localparam int unsigned FacW = 33;
  localparam int unsigned ProdW = 66;
  localparam int unsigned FracBits = 27;

  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_START  = 2'd1,
    KIND_QUERY  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  // Division request to the shared divider.
  typedef struct packed {
    logic                     start;
    logic                     neg;
    logic [ProdW-1:0]         num;
    logic [ProdW-1:0]         den;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [CoordW-1:0] quo;
  } div_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RD0, ST_RD1, ST_SCAN, ST_RDX, ST_WAITX, ST_FAC, ST_MUL1,
    ST_MUL2, ST_DIV, ST_DIVW, ST_OUT, ST_NF
  } state_t;

endpackage

/* rtl/core/interval_lagrange_weights_1d.sv */
// A query scans the intervals in turn through the single point RAM port, then
// computes each weight by factor setup, two product steps and a wait on the
// shared bit-serial divider.
// Reset (synchronous, active high) empties the point set; RAM is not cleared.
// ---------------------------------------------------------------------------
// interval_lagrange_weights_1d
// Loads ascending sample points and emits Lagrange weights for a query.
// ---------------------------------------------------------------------------
`include "interval_lagrange_weights_1d_assert.svh"
module interval_lagrange_weights_1d #(
  parameter int unsigned MAX_POINTS = ilw_pkg::MaxPointsDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          valid_in,
  output logic                          ready_in,
  input  logic [1:0]                    kind,
  input  logic signed [ilw_pkg::CoordW-1:0] coord_value,
  output logic                          valid_out,
  input  logic                          ready_out,
  output logic [ilw_pkg::IdxW-1:0]      neighbour_index,
  output logic signed [ilw_pkg::CoordW-1:0] weight,
  output logic                          status,
  output logic                          last
);
  import ilw_pkg::*;

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  state_t state, state_next;

  logic [CW-1:0]            count;
  logic [CW-1:0]            scan;      // index i of the interval
  logic signed [CoordW-1:0] x, p0, p1, p2, pm;
  logic [1:0]               term;      // which weight: 0,1,2
  logic                     fwd;
  logic [AW-1:0]            ram_addr;
  logic                     ram_we;
  logic [CoordW-1:0]        ram_rd;
  logic signed [FacW-1:0]   fa, fb, fc, fd;
  logic [ProdW-1:0]         pnum, pden;
  logic                     pneg;
  div_req_t                 dreq;
  div_rsp_t                 drsp;
  logic signed [CoordW-1:0] wq;
  logic [CW-1:0]            oidx;
  logic                     req_acc;
  logic                     out_acc;

  assign req_acc = valid_in && ready_in;
  assign out_acc = valid_out && ready_out;
  assign ready_in = (state == ST_IDLE);

  ilw_ram #(.Width(CoordW), .Depth(MAX_POINTS)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(coord_value), .rdata(ram_rd)
  );

  ilw_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  function automatic logic [FacW-1:0] absf(input logic signed [FacW-1:0] v);
    absf = v[FacW-1] ? -v : v;
  endfunction

  // Store write on append/start, otherwise address follows the scan.
  always_comb begin
    ram_we   = 1'b0;
    ram_addr = scan[AW-1:0];
    if (req_acc) begin
      if (kind == KIND_APPEND && count < CW'(MAX_POINTS)) begin
        ram_we   = 1'b1;
        ram_addr = count[AW-1:0];
      end else if (kind == KIND_START) begin
        ram_we   = 1'b1;
        ram_addr = '0;
      end else begin
        ram_addr = '0;
      end
    end else if (state == ST_RD0 || state == ST_RD1) begin
      ram_addr = AW'(scan + CW'(1));
    end else if (state == ST_SCAN) begin
      ram_addr = AW'(scan + CW'(2));
    end else if (state == ST_RDX) begin
      ram_addr = fwd ? AW'(scan + CW'(2)) : AW'(scan - CW'(1));
    end
  end

  // Factor selection for the current weight.
  always_comb begin
    logic signed [FacW-1:0] sx, s0, s1, s2, sm;
    sx = FacW'(x);  s0 = FacW'(p0); s1 = FacW'(p1); s2 = FacW'(p2); sm = FacW'(pm);
    fa = s1 - sx; fb = 33'sd1; fc = s1 - s0; fd = 33'sd1;
    if (count == CW'(2)) begin
      if (term != 2'd0) fa = sx - s0;
    end else if (fwd) begin
      unique case (term)
        2'd0: begin fa = s1 - sx; fb = s2 - sx; fc = s1 - s0; fd = s2 - s0; end
        2'd1: begin fa = sx - s0; fb = s2 - sx; fc = s1 - s0; fd = s2 - s1; end
        default: begin fa = sx - s0; fb = sx - s1; fc = s2 - s0; fd = s2 - s1; end
      endcase
    end else begin
      unique case (term)
        2'd0: begin fa = s1 - sx; fb = sx - sm; fc = s1 - s0; fd = s0 - sm; end
        2'd1: begin fa = sx - s0; fb = sx - sm; fc = s1 - s0; fd = s1 - sm; end
        default: begin fa = s0 - sx; fb = s1 - sx; fc = s0 - sm; fd = s1 - sm; end
      endcase
    end
  end

  logic signed [FacW-1:0] ra, rb, rc, rd;

  always_comb begin
    state_next = state;
    dreq       = '0;
    dreq.num   = pnum;
    dreq.den   = pden;
    dreq.neg   = pneg;
    unique case (state)
      ST_IDLE: if (req_acc && kind == KIND_QUERY) begin
        state_next = (count < CW'(2)) ? ST_NF : ST_RD0;
      end
      ST_RD0:  state_next = ST_RD1;   // p[0] data arrives
      ST_RD1:  state_next = ST_SCAN;  // p[i+1] data arrives
      ST_SCAN: begin
        if (p0 <= x && x <= $signed(ram_rd)) state_next = ST_RDX;
        else if (scan + CW'(2) >= count) state_next = ST_NF;
      end
      ST_RDX:   state_next = ST_WAITX;
      ST_WAITX: state_next = ST_FAC;
      ST_FAC:   state_next = ST_MUL1;
      ST_MUL1:  state_next = ST_MUL2;
      ST_MUL2:  state_next = ST_DIV;
      ST_DIV: begin
        dreq.start = 1'b1;
        state_next = ST_DIVW;
      end
      ST_DIVW:  if (drsp.done) state_next = ST_OUT;
      ST_OUT: if (out_acc) begin
        state_next = last ? ST_IDLE : ST_FAC;
      end
      ST_NF: if (out_acc) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (req_acc) begin
        if (kind == KIND_APPEND && count < CW'(MAX_POINTS)) count <= count + CW'(1);
        else if (kind == KIND_START) count <= CW'(1);
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        x    <= coord_value;
        scan <= '0;
        term <= 2'd0;
      end
      ST_RD0:  p0 <= $signed(ram_rd);
      ST_SCAN: begin
        p1 <= $signed(ram_rd);
        if (!(p0 <= x && x <= $signed(ram_rd))) begin
          p0   <= $signed(ram_rd);
          scan <= scan + CW'(1);
        end else begin
          fwd <= (scan + CW'(2) < count);
        end
      end
      ST_WAITX: begin
        p2 <= $signed(ram_rd);
        pm <= $signed(ram_rd);
      end
      ST_FAC: begin
        ra <= fa; rb <= fb; rc <= fc; rd <= fd;
      end
      ST_MUL1: begin
        pnum <= ProdW'(absf(ra)) * ProdW'(absf(rb));
        pneg <= ra[FacW-1] ^ rb[FacW-1];
      end
      ST_MUL2: begin
        pden <= ProdW'(absf(rc)) * ProdW'(absf(rd));
        pneg <= pneg ^ rc[FacW-1] ^ rd[FacW-1];
      end
      ST_DIVW: if (drsp.done) wq <= drsp.quo;
      ST_OUT: if (out_acc) term <= term + 2'd1;
      default: ;
    endcase
  end

  // Result fields.
  always_comb begin
    unique case (term)
      2'd0:    oidx = scan;
      2'd1:    oidx = scan + CW'(1);
      default: oidx = fwd ? scan + CW'(2) : scan - CW'(1);
    endcase
  end

  assign valid_out       = (state == ST_OUT) || (state == ST_NF);
  assign status          = (state == ST_NF);
  assign neighbour_index = status ? '0 : IdxW'(oidx);
  assign weight          = status ? '0 : wq;
  assign last            = status ||
                           (count == CW'(2) ? term == 2'd1 : term == 2'd2);

  `ILW_ASSERT_IMP(a_no_ready_busy, clk, rst, state != ST_IDLE, !ready_in,
    "ready while busy")
  `ILW_ASSERT_IMP(a_nf_fields, clk, rst, valid_out && status,
    last && weight == '0, "not-found result malformed")
  `ILW_ASSERT_NEXT(a_last_idle, clk, rst, out_acc && last, ready_in,
    "no return to idle after last result")
endmodule

/* rtl/core/ilw_ram.sv */
// ---------------------------------------------------------------------------
// ilw_ram
// Generic single-port RAM with registered read.
// ---------------------------------------------------------------------------
module ilw_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

/* rtl/core/ilw_div.sv */
// ---------------------------------------------------------------------------
// ilw_div
// Restoring divider: Q4.27 rounded, saturated quotient, one bit per cycle.
// ---------------------------------------------------------------------------
module ilw_div (
  input  logic               clk,
  input  logic               rst,
  input  ilw_pkg::div_req_t  req,
  output ilw_pkg::div_rsp_t  rsp
);
  import ilw_pkg::*;

  // Room for the denominator shifted up by the full 32-bit quotient range.
  localparam int unsigned RemW = ProdW + 32;

  logic              busy;
  logic [5:0]        bitn;
  logic [RemW-1:0]   rem;
  logic [RemW-1:0]   den;
  logic [31:0]       q;
  logic              neg;
  logic              sat;
  logic              zero;
  logic [RemW-1:0]   numx;
  logic [RemW-1:0]   trial;
  logic [32:0]       qr;

  assign numx  = {{(RemW-ProdW){1'b0}}, req.num} << FracBits;
  assign trial = den << bitn[4:0];

  always_comb begin
    qr = {1'b0, q} + {32'd0, ((rem << 1) >= den)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        bitn <= 6'd31;
        rem  <= numx;
        den  <= {{(RemW-ProdW){1'b0}}, req.den};
        neg  <= req.neg;
        q    <= '0;
        zero <= (req.den == '0);
        sat  <= (req.den == '0) ? (req.num != '0)
              : (numx >= ({{(RemW-ProdW){1'b0}}, req.den} << 32));
      end else if (busy) begin
        if (!bitn[5]) begin
          if (rem >= trial) begin
            rem <= rem - trial;
            q[bitn[4:0]] <= 1'b1;
          end
          bitn <= bitn - 6'd1;
        end else begin
          busy     <= 1'b0;
          rsp.done <= 1'b1;
          // Round, apply sign, saturate.
          if (zero && !sat) begin
            rsp.quo <= '0;
          end else if (sat) begin
            rsp.quo <= neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
          end else if (neg) begin
            rsp.quo <= (qr > 33'h0_8000_0000) ? 32'sh8000_0000 : -$signed(qr[31:0]);
          end else begin
            rsp.quo <= (qr > 33'h0_7fff_ffff) ? 32'sh7fff_ffff : $signed(qr[31:0]);
          end
        end
      end
    end
  end
endmodule

/* tb/sv/testbench.sv */
// ---------------------------------------------------------------------------
// interval_lagrange_weights_1d testbench
// Loads point sets of random size and spacing into the block and fires
// queries at them, inside and outside the sampled range. Every result is
// checked, field by field, against a predictor of the interval scan and the
// Lagrange weight arithmetic, while both handshakes stall at random.
// ---------------------------------------------------------------------------
module testbench;
  import ilw_pkg::*;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              valid_in = 1'b0;
  logic              ready_in;
  logic [1:0]        kind = KIND_NONE;
  logic signed [31:0] coord_value = '0;
  logic              valid_out;
  logic              ready_out = 1'b0;
  logic [9:0]        neighbour_index;
  logic signed [31:0] weight;
  logic              status;
  logic              last;

  interval_lagrange_weights_1d u_dut (
    .clk(clk), .rst(rst),
    .valid_in(valid_in), .ready_in(ready_in),
    .kind(kind), .coord_value(coord_value),
    .valid_out(valid_out), .ready_out(ready_out),
    .neighbour_index(neighbour_index), .weight(weight),
    .status(status), .last(last)
  );

  always #5 clk = ~clk;

  typedef struct packed {
    logic [9:0]  idx;
    logic [31:0] w;
    logic        st;
    logic        fin;
  } weight_rec_t;

  // One stimulus row: request, and optionally a single expected result.
  typedef struct {
    kind_t       k;
    logic [31:0] v;
    bit          typed;
    weight_rec_t want;
  } stim_row_t;

  localparam int unsigned WatchdogLimit = 200000;
  localparam int unsigned NPoints = 1024;
  localparam int unsigned LongSet = 64;

  // Predictor state.
  logic signed [31:0] pts [NPoints];
  int unsigned        npts;
  weight_rec_t        pending_weights [$];

  int  errors;
  int  n_req, n_res, n_query, n_nf, n_sat;
  int  idle_cycles;
  bit  stim_done;

  // Largest coordinate already in the set, for building ascending sets.
  logic signed [31:0] top_pt;

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  // (a*b)/(c*d) in Q4.27, rounded half away from zero, saturated.
  function automatic logic [31:0] lagrange_ratio(input logic signed [63:0] a,
      input logic signed [63:0] b, input logic signed [63:0] c,
      input logic signed [63:0] d);
    bit           neg;
    logic [127:0] num, den, rem;
    logic [63:0]  q;
    neg = ((a < 0) != (b < 0)) ^ ((c < 0) != (d < 0));
    num = (128'(mag64(a)) * 128'(mag64(b))) << 27;
    den = 128'(mag64(c)) * 128'(mag64(d));
    if (den == 0) begin
      if (num == 0) return 32'd0;
      return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    if (num >= (den << 32)) return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    q = num / den;
    rem = num - 128'(q) * den;
    if ((rem << 1) >= den) q++;
    if (neg) return q > 64'h8000_0000 ? 32'h8000_0000 : 32'(-q);
    return q > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : q[31:0];
  endfunction

  function automatic void push_weight(input int unsigned i, input logic [31:0] w,
      input bit fin);
    weight_rec_t r;
    r.idx = i[9:0];
    r.w = w;
    r.st = 1'b0;
    r.fin = fin;
    if (w == 32'h7FFF_FFFF || w == 32'h8000_0000) n_sat++;
    pending_weights.insert(pending_weights.size(), r);
  endfunction

  // Advance the predictor by one accepted request.
  function automatic void predict(input kind_t k, input logic signed [31:0] v);
    logic signed [63:0] x, p0, p1, p2, pm;
    weight_rec_t nf;
    case (k)
      KIND_APPEND: begin
        if (npts < NPoints) begin
          pts[npts] = v;
          npts++;
        end
      end
      KIND_START: begin
        pts[0] = v;
        npts = 1;
      end
      KIND_QUERY: begin
        n_query++;
        x = v;
        for (int unsigned i = 0; i + 1 < npts; i++) begin
          p0 = pts[i];
          p1 = pts[i+1];
          if (p0 <= x && x <= p1) begin
            if (npts == 2) begin
              push_weight(i, lagrange_ratio(p1 - x, 1, p1 - p0, 1), 1'b0);
              push_weight(i + 1, lagrange_ratio(x - p0, 1, p1 - p0, 1), 1'b1);
            end else if (i + 2 < npts) begin
              p2 = pts[i+2];
              push_weight(i, lagrange_ratio(p1 - x, p2 - x, p1 - p0, p2 - p0), 1'b0);
              push_weight(i + 1, lagrange_ratio(x - p0, p2 - x, p1 - p0, p2 - p1), 1'b0);
              push_weight(i + 2, lagrange_ratio(x - p0, x - p1, p2 - p0, p2 - p1), 1'b1);
            end else begin
              // Last interval: backward stencil on i-1.
              pm = pts[i-1];
              push_weight(i, lagrange_ratio(p1 - x, x - pm, p1 - p0, p0 - pm), 1'b0);
              push_weight(i + 1, lagrange_ratio(x - p0, x - pm, p1 - p0, p1 - pm), 1'b0);
              push_weight(i - 1, lagrange_ratio(p0 - x, p1 - x, p0 - pm, p1 - pm), 1'b1);
            end
            return;
          end
        end
        nf.idx = '0; nf.w = '0; nf.st = 1'b1; nf.fin = 1'b1;
        n_nf++;
        pending_weights.insert(pending_weights.size(), nf);
      end
      default: ;
    endcase
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Drive one request and hold it until accepted.
  task automatic send(input kind_t k, input logic [31:0] v);
    int unsigned g;
    g = gap_len();
    if (g != 0) begin
      valid_in <= 1'b0;
      repeat (g) @(negedge clk);
    end
    valid_in <= 1'b1;
    kind <= k;
    coord_value <= v;
    @(posedge clk);
    while (!ready_in) @(posedge clk);
    predict(k, v);
    n_req++;
    if (k == KIND_START) top_pt = v;
    if (k == KIND_APPEND) top_pt = v;
    @(negedge clk);
  endtask

  // Send a query whose single expected result is typed in.
  task automatic send_typed(input stim_row_t row);
    weight_rec_t got;
    send(row.k, row.v);
    got = pending_weights[pending_weights.size() - 1];
    if (got != row.want) begin
      $error("typed row: predictor idx=%0d w=%0h st=%0b last=%0b",
             got.idx, got.w, got.st, got.fin);
      errors++;
    end
  endtask

  // Load an ascending set of n points with random spacing.
  task automatic load_set(input int unsigned n, input int unsigned span);
    logic signed [31:0] p;
    p = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
    send(KIND_START, p);
    for (int unsigned i = 1; i < n; i++) begin
      // Repeat a coordinate now and then to hit zero-width intervals.
      if ($urandom_range(0, 19) != 0) p = p + $signed($urandom_range(1, span));
      send(KIND_APPEND, p);
    end
  endtask

  function automatic logic [31:0] query_coord();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 7 && npts >= 2) begin
      // Inside the set, sometimes exactly on a point.
      int unsigned i;
      i = $urandom_range(0, npts - 2);
      if (r == 0) return pts[i];
      return pts[i] + ($signed(pts[i+1] - pts[i]) > 0 ?
                       32'($urandom_range(0, 32'(pts[i+1] - pts[i]))) : 32'd0);
    end
    if (r == 7) return 32'h8000_0000 | $urandom_range(0, 255);
    if (r == 8) return 32'h7FFF_FF00 | $urandom_range(0, 255);
    return $urandom();
  endfunction

  // Result side: random stall, check each accepted result.
  initial begin
    weight_rec_t exp_w;
    @(negedge clk);
    forever begin
      ready_out <= ($urandom_range(0, 99) < 65) || (gap_len() == 0);
      @(posedge clk);
      if (valid_out && ready_out && !rst) begin
        n_res++;
        if (pending_weights.size() == 0) begin
          $error("result with nothing expected: idx=%0d weight=%0h", neighbour_index, weight);
          errors++;
        end else begin
          exp_w = pending_weights.pop_front();
          if (neighbour_index !== exp_w.idx) begin
            $error("neighbour_index: expected %0d, got %0d", exp_w.idx, neighbour_index);
            errors++;
          end
          if (weight !== exp_w.w) begin
            $error("weight: expected %0h, got %0h", exp_w.w, weight);
            errors++;
          end
          if (status !== exp_w.st) begin
            $error("status: expected %0b, got %0b", exp_w.st, status);
            errors++;
          end
          if (last !== exp_w.fin) begin
            $error("last: expected %0b, got %0b", exp_w.fin, last);
            errors++;
          end
        end
      end
      @(negedge clk);
    end
  end

  // Watchdog: count cycles in which no handshake completes.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((valid_in && ready_in) || (valid_out && ready_out) || rst) idle_cycles = 0;
      else if (!stim_done || pending_weights.size() != 0) idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog: no handshake for %0d cycles", WatchdogLimit);
        $display("interval_lagrange_weights_1d test failed");
        $finish;
      end
    end
  end

  stim_row_t rows [$];
  stim_row_t row;

  initial begin
    weight_rec_t nf;
    int unsigned sz;
    errors = 0; npts = 0; stim_done = 0;
    n_req = 0; n_res = 0; n_query = 0; n_nf = 0; n_sat = 0;
    nf.idx = '0; nf.w = '0; nf.st = 1'b1; nf.fin = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table. Typed rows carry a not-found result.
    rows = '{
      '{KIND_QUERY, 32'h0000_0000, 1'b1, nf},   // empty set after reset
      '{KIND_NONE,  32'hFFFF_FFFF, 1'b0, nf},   // unused kind, ignored
      '{KIND_START, 32'h0001_0000, 1'b0, nf},
      '{KIND_QUERY, 32'h0001_0000, 1'b1, nf},   // one point only
      '{KIND_APPEND, 32'h0003_0000, 1'b0, nf},
      '{KIND_QUERY, 32'h0002_0000, 1'b0, nf},   // linear pair, middle
      '{KIND_QUERY, 32'h0001_0000, 1'b0, nf},   // linear pair, on left end
      '{KIND_QUERY, 32'h7FFF_FFFF, 1'b1, nf},   // above range
      '{KIND_QUERY, 32'h8000_0000, 1'b1, nf},   // below range
      '{KIND_APPEND, 32'h0007_0000, 1'b0, nf},
      '{KIND_QUERY, 32'h0001_8000, 1'b0, nf},   // forward stencil
      '{KIND_QUERY, 32'h0005_0000, 1'b0, nf},   // backward stencil, last interval
      '{KIND_QUERY, 32'h0007_0000, 1'b0, nf},   // on last point
      '{KIND_START, 32'h8000_0000, 1'b0, nf},   // widest coordinates
      '{KIND_APPEND, 32'h0000_0000, 1'b0, nf},
      '{KIND_APPEND, 32'h7FFF_FFFF, 1'b0, nf},
      '{KIND_QUERY, 32'h8000_0001, 1'b0, nf},
      '{KIND_QUERY, 32'h7FFF_FFFE, 1'b0, nf},
      '{KIND_START, 32'h0000_1000, 1'b0, nf},   // repeated points: zero width
      '{KIND_APPEND, 32'h0000_1000, 1'b0, nf},
      '{KIND_APPEND, 32'h0000_1000, 1'b0, nf},
      '{KIND_QUERY, 32'h0000_1000, 1'b0, nf},
      '{KIND_START, 32'h0000_0000, 1'b0, nf},
      '{KIND_APPEND, 32'h0000_0001, 1'b0, nf},
      '{KIND_APPEND, 32'h7FFF_0000, 1'b0, nf},
      '{KIND_QUERY, 32'h4000_0000, 1'b0, nf}    // saturating weights
    };
    foreach (rows[r]) begin
      row = rows[r];
      if (row.typed) send_typed(row);
      else send(row.k, row.v);
    end

    // Random part: small sets with queries, plus noise.
    while (n_req < 300) begin
      sz = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 12);
      if (sz == 0) begin
        send(KIND_QUERY, $urandom());
      end else begin
        load_set(sz, ($urandom_range(0, 3) == 0) ? 32'h0100_0000 : 32'h0004_0000);
        repeat ($urandom_range(2, 8)) begin
          case ($urandom_range(0, 19))
            0: send(KIND_NONE, $urandom());
            1: send(KIND_APPEND, top_pt + $urandom_range(0, 32'h0002_0000));
            default: send(KIND_QUERY, query_coord());
          endcase
        end
      end
    end

    // Load a longer set and query its last and first interval.
    send(KIND_START, 32'hC000_0000);
    for (int unsigned i = 1; i < LongSet; i++)
      send(KIND_APPEND, 32'hC000_0000 + 32'(i) * 32'h0010_0000);
    send(KIND_QUERY, 32'hC000_0000 + 32'(LongSet - 1) * 32'h0010_0000 - 32'h8_0000);
    send(KIND_QUERY, 32'hC000_0000 + 32'h8_0000);
    valid_in <= 1'b0;

    stim_done = 1;
    while (pending_weights.size() != 0) @(posedge clk);
    repeat (3000) @(posedge clk);

    $display("covered %0d requests, %0d queries, %0d results (%0d not found, %0d saturated)",
             n_req, n_query, n_res, n_nf, n_sat);
    if (errors == 0) begin
      $display("interval_lagrange_weights_1d test passed");
    end else begin
      $display("interval_lagrange_weights_1d test failed");
    end
    $finish;
  end

endmodule
